FILE: design/rau_pkg.sv
package rau_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned WideWidth = 64;
   localparam int unsigned DenWidth  = 31;
   localparam int unsigned KindWidth = 3;
   localparam int unsigned StatWidth = 2;
   localparam int unsigned CntWidth  = 6;
   localparam int unsigned ShWidth   = 6;

   localparam int unsigned ReqDataWidth = 128;
   localparam int unsigned RspDataWidth = 64;

   typedef enum logic [KindWidth-1:0] {
      KIND_ADD   = 3'd0,
      KIND_SUB   = 3'd1,
      KIND_MUL   = 3'd2,
      KIND_DIV   = 3'd3,
      KIND_NEG   = 3'd4,
      KIND_RECIP = 3'd5,
      KIND_ROUND = 3'd6,
      KIND_MAKE  = 3'd7
   } kind_type;

   typedef enum logic [StatWidth-1:0] {
      ST_OK    = 2'd0,
      ST_DIVZ  = 2'd1,
      ST_RANGE = 2'd2,
      ST_RSVD  = 2'd3
   } stat_type;

   typedef enum logic [1:0] {
      DSEL_ROUND = 2'd0,
      DSEL_NUM   = 2'd1,
      DSEL_DEN   = 2'd2,
      DSEL_NONE  = 2'd3
   } dsel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MUL,
      S_RDIV,
      S_RFIX,
      S_COMBINE,
      S_ZCHK,
      S_GCD,
      S_NDIV,
      S_NTAKE,
      S_DDIV,
      S_DTAKE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                load;
      logic                mul_step;
      logic [1:0]          mul_idx;
      logic                combine;
      logic                div_init;
      dsel_type            div_sel;
      logic                div_step;
      logic                round_fix;
      logic                gcd_init;
      logic                gcd_step;
      logic                take_num;
      logic                take_den;
      logic                write_out;
   } cmd_type;

   typedef struct packed {
      logic                err;
      logic                is_round;
      logic                num_zero;
      logic                gcd_done;
      logic                out_busy;
   } stat_bus_type;

endpackage

FILE: design/rau_ctrl.sv
module rau_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  rau_pkg::stat_bus_type dp_stat,
   output logic                  req_ready,
   output rau_pkg::cmd_type      cmd
);
   import rau_pkg::*;

   state_type            state_ff, state_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;

   localparam logic [CntWidth-1:0] CntLast = CntWidth'(WideWidth - 1);
   localparam logic [CntWidth-1:0] MulLast = CntWidth'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.div_sel = DSEL_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cnt_in = '0;
            state_in = dp_stat.err ? S_FINISH : S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cmd.mul_idx  = cnt_ff[1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MulLast) begin
               cnt_in = '0;
               if (dp_stat.is_round) begin
                  cmd.div_init = 1'b1;
                  cmd.div_sel  = DSEL_ROUND;
                  state_in = S_RDIV;
               end else begin
                  state_in = S_COMBINE;
               end
            end
         end
         S_RDIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) state_in = S_RFIX;
         end
         S_RFIX: begin
            cmd.round_fix = 1'b1;
            state_in = S_ZCHK;
         end
         S_COMBINE: begin
            cmd.combine = 1'b1;
            state_in = S_ZCHK;
         end
         S_ZCHK: begin
            if (dp_stat.num_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (dp_stat.gcd_done) begin
               cmd.div_init = 1'b1;
               cmd.div_sel  = DSEL_NUM;
               cnt_in = '0;
               state_in = S_NDIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_NDIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) state_in = S_NTAKE;
         end
         S_NTAKE: begin
            cmd.take_num = 1'b1;
            cmd.div_init = 1'b1;
            cmd.div_sel  = DSEL_DEN;
            cnt_in = '0;
            state_in = S_DDIV;
         end
         S_DDIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) state_in = S_DTAKE;
         end
         S_DTAKE: begin
            cmd.take_den = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!dp_stat.out_busy) begin
               cmd.write_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: design/rau_dp.sv
module rau_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  rau_pkg::cmd_type                    cmd,
   output rau_pkg::stat_bus_type               dp_stat,
   input  logic [rau_pkg::KindWidth-1:0]       kind,
   input  logic signed [rau_pkg::WordWidth-1:0] a_num,
   input  logic signed [rau_pkg::WordWidth-1:0] a_den,
   input  logic signed [rau_pkg::WordWidth-1:0] b_num,
   input  logic [rau_pkg::DenWidth-1:0]        b_den,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [rau_pkg::WordWidth-1:0] res_num,
   output logic [rau_pkg::DenWidth-1:0]        res_den,
   output logic [rau_pkg::StatWidth-1:0]       status
);
   import rau_pkg::*;

   kind_type               kind_ff;
   logic [WordWidth-1:0]   anm_ff, adm_ff, bnm_ff, bd_ff;
   logic                   sa_ff, sb_ff;
   stat_type               err_ff, err_in;
   logic [WordWidth-1:0]   anm_in, adm_in, bnm_in;

   logic [WideWidth-1:0]   p0_ff, p1_ff, p2_ff;
   logic [WordWidth-1:0]   ma, mb;
   logic [WideWidth-1:0]   prod;

   logic [WideWidth-1:0]   n_ff, d_ff;
   logic                   neg_ff;

   logic [WideWidth-1:0]   dvd_ff, rem_ff, dvs_ff;
   logic [WideWidth:0]     sh_rem;
   logic                   q_bit;

   logic [WideWidth-1:0]   u_ff, v_ff, g_val;
   logic [ShWidth-1:0]     k_ff;

   logic                   out_valid_ff;
   logic [WordWidth-1:0]   rnum_ff;
   logic [DenWidth-1:0]    rden_ff;
   stat_type               rstat_ff;

   logic                   s2;
   logic [WideWidth:0]     diff;
   logic                   rnd_up;
   logic                   over;
   logic [WordWidth-1:0]   n_low;

   // operand magnitudes and the early error code
   always_comb begin
      anm_in = a_num[WordWidth-1] ? (~a_num + 1'b1) : a_num;
      adm_in = a_den[WordWidth-1] ? (~a_den + 1'b1) : a_den;
      bnm_in = b_num[WordWidth-1] ? (~b_num + 1'b1) : b_num;
      err_in = ST_OK;
      if (adm_in == '0) err_in = ST_DIVZ;
      else if ((kind <= KIND_DIV) && (b_den == '0)) err_in = ST_DIVZ;
      else if ((kind == KIND_DIV) && (bnm_in == '0)) err_in = ST_DIVZ;
      else if ((kind == KIND_RECIP) && (anm_in == '0)) err_in = ST_DIVZ;
   end

   // shared multiplier, one product per cycle
   always_comb begin
      ma = adm_ff;
      mb = bnm_ff;
      case (cmd.mul_idx)
         2'd0: begin
            ma = anm_ff;
            mb = (kind_ff == KIND_MUL) ? bnm_ff : bd_ff;
         end
         2'd1: begin
            ma = bnm_ff;
            mb = adm_ff;
         end
         default: begin
            ma = adm_ff;
            mb = (kind_ff == KIND_DIV) ? bnm_ff : bd_ff;
         end
      endcase
      prod = ma * mb;
   end

   assign sh_rem = {rem_ff, dvd_ff[WideWidth-1]};
   assign q_bit  = sh_rem >= {1'b0, dvs_ff};
   assign g_val  = u_ff << k_ff;
   assign s2     = (kind_ff == KIND_SUB) ? ~sb_ff : sb_ff;
   assign diff   = {1'b0, p0_ff} - {1'b0, p1_ff};
   assign rnd_up = {rem_ff, 1'b0} >= {1'b0, 32'd0, adm_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_type'(kind);
         anm_ff  <= anm_in;
         adm_ff  <= adm_in;
         bnm_ff  <= bnm_in;
         bd_ff   <= {1'b0, b_den};
         sa_ff   <= a_num[WordWidth-1] ^ a_den[WordWidth-1];
         sb_ff   <= b_num[WordWidth-1];
         err_ff  <= err_in;
      end
      if (cmd.mul_step) begin
         case (cmd.mul_idx)
            2'd0:    p0_ff <= prod;
            2'd1:    p1_ff <= prod;
            default: p2_ff <= prod;
         endcase
      end
      if (cmd.combine) begin
         case (kind_ff)
            KIND_ADD, KIND_SUB: begin
               d_ff <= p2_ff;
               if (sa_ff == s2) begin
                  n_ff   <= p0_ff + p1_ff;
                  neg_ff <= sa_ff;
               end else if (!diff[WideWidth]) begin
                  n_ff   <= diff[WideWidth-1:0];
                  neg_ff <= sa_ff;
               end else begin
                  n_ff   <= p1_ff - p0_ff;
                  neg_ff <= s2;
               end
            end
            KIND_MUL, KIND_DIV: begin
               n_ff   <= p0_ff;
               d_ff   <= p2_ff;
               neg_ff <= sa_ff ^ sb_ff;
            end
            KIND_NEG: begin
               n_ff   <= {32'd0, anm_ff};
               d_ff   <= {32'd0, adm_ff};
               neg_ff <= ~sa_ff;
            end
            KIND_RECIP: begin
               n_ff   <= {32'd0, adm_ff};
               d_ff   <= {32'd0, anm_ff};
               neg_ff <= sa_ff;
            end
            default: begin
               n_ff   <= {32'd0, anm_ff};
               d_ff   <= {32'd0, adm_ff};
               neg_ff <= sa_ff;
            end
         endcase
      end
      if (cmd.round_fix) begin
         n_ff   <= dvd_ff + {63'd0, rnd_up};
         d_ff   <= 64'd1;
         neg_ff <= sa_ff;
      end
      if (cmd.take_num) n_ff <= dvd_ff;
      if (cmd.take_den) d_ff <= dvd_ff;
      // restoring divider, one quotient bit per cycle
      if (cmd.div_init) begin
         rem_ff <= '0;
         case (cmd.div_sel)
            DSEL_ROUND: begin
               dvd_ff <= {32'd0, anm_ff};
               dvs_ff <= {32'd0, adm_ff};
            end
            DSEL_NUM: begin
               dvd_ff <= n_ff;
               dvs_ff <= g_val;
            end
            default: begin
               dvd_ff <= d_ff;
               dvs_ff <= g_val;
            end
         endcase
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? WideWidth'(sh_rem - {1'b0, dvs_ff}) : sh_rem[WideWidth-1:0];
         dvd_ff <= {dvd_ff[WideWidth-2:0], q_bit};
      end
      // binary gcd, one step per cycle
      if (cmd.gcd_init) begin
         u_ff <= n_ff;
         v_ff <= d_ff;
         k_ff <= '0;
      end else if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff > v_ff) begin
            u_ff <= v_ff;
            v_ff <= u_ff - v_ff;
         end else begin
            v_ff <= v_ff - u_ff;
         end
      end
   end

   assign over  = (d_ff > 64'h7FFF_FFFF) ||
                  (n_ff > (neg_ff ? 64'h8000_0000 : 64'h7FFF_FFFF));
   assign n_low = n_ff[WordWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.write_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_out) begin
         if (err_ff != ST_OK) begin
            rnum_ff  <= '0;
            rden_ff  <= DenWidth'(1);
            rstat_ff <= err_ff;
         end else if (n_ff == '0) begin
            rnum_ff  <= '0;
            rden_ff  <= DenWidth'(1);
            rstat_ff <= ST_OK;
         end else if (over) begin
            rnum_ff  <= '0;
            rden_ff  <= DenWidth'(1);
            rstat_ff <= ST_RANGE;
         end else begin
            rnum_ff  <= neg_ff ? (~n_low + 1'b1) : n_low;
            rden_ff  <= d_ff[DenWidth-1:0];
            rstat_ff <= ST_OK;
         end
      end
   end

   assign dp_stat.err      = (err_ff != ST_OK);
   assign dp_stat.is_round = (kind_ff == KIND_ROUND);
   assign dp_stat.num_zero = (n_ff == '0);
   assign dp_stat.gcd_done = (v_ff == '0);
   assign dp_stat.out_busy = out_valid_ff & ~rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign res_num   = rnum_ff;
   assign res_den   = rden_ff;
   assign status    = rstat_ff;

endmodule

FILE: design/rational_arithmetic_unit_top.sv
// Exact arithmetic on 32-bit rationals, reduced to lowest terms.
// Input channel (req_*): one transaction per item; req_tuser carries the
// operation kind, req_tdata the operands a = a_num/a_den and b = b_num/b_den.
// Result channel (rsp_*): one transaction per item with the reduced
// numerator and denominator in rsp_tdata and the status code in rsp_tuser
// (0 ok, 1 division by zero, 2 out of int32 range; on error 0/1).
// One item is worked at a time. After accept the controller runs the
// multiplies, then the binary gcd (one subtract or shift per cycle), then
// two restoring divisions by the gcd, each followed by a take step;
// round adds one more restoring division ahead of the gcd.
// Errors found at the operand check skip the arithmetic and go straight to the finish state.
// The result sits in an output register, so a stalled receiver does not
// block the next item from being accepted and worked; only the write of a
// new result waits until the previous one is taken.
// Reset returns the controller to idle and drops any pending result.
module rational_arithmetic_unit_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[126:96], zero pad
   input  logic [rau_pkg::ReqDataWidth-1:0]     req_tdata,
   // kind[2:0]
   input  logic [rau_pkg::KindWidth-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // res_num[31:0], res_den[62:32], zero pad
   output logic [rau_pkg::RspDataWidth-1:0]     rsp_tdata,
   // status[1:0]
   output logic [rau_pkg::StatWidth-1:0]        rsp_tuser
);
   import rau_pkg::*;

   cmd_type              cmd;
   stat_bus_type         dp_stat;
   logic                 req_fire;
   logic [WordWidth-1:0] res_num;
   logic [DenWidth-1:0]  res_den;

   // accept a transaction only while the controller is idle
   assign req_fire = req_tvalid & req_tready;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .dp_stat   (dp_stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   rau_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .dp_stat   (dp_stat),
      .kind      (req_tuser),
      .a_num     (req_tdata[31:0]),
      .a_den     (req_tdata[63:32]),
      .b_num     (req_tdata[95:64]),
      .b_den     (req_tdata[126:96]),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .res_num   (res_num),
      .res_den   (res_den),
      .status    (rsp_tuser)
   );

   // pack result fields, lowest first, pad to whole bytes
   assign rsp_tdata = {1'b0, res_den, res_num};

endmodule
